// File: rtl/hslr_pkg.sv
// Shared constants, event and register codes, status type and colour helpers
// for the HSL ramp sequencer. Used by the serial units and the top level.
package hslr_pkg;

  // Fraction bits of the fixed-point colour and time ratios.
  localparam int unsigned FracBits = 16;
  // Colour parts and ratios run from zero to one inclusive.
  localparam int unsigned FixW     = FracBits + 1;
  localparam int unsigned MulW     = FixW;
  localparam int unsigned ProdW    = 2 * MulW;
  localparam int unsigned MulCntW  = $clog2(MulW + 1);
  localparam int unsigned NumW     = 15;
  localparam int unsigned DenW     = 14;
  localparam int unsigned DivSteps = FracBits;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  localparam logic [FixW-1:0] One       = FixW'(1) << FracBits;
  localparam logic [FixW-1:0] Sixth     = FixW'(10922);
  localparam logic [FixW-1:0] Half      = FixW'(32768);
  localparam logic [FixW-1:0] Third     = FixW'(21845);
  localparam logic [FixW-1:0] TwoThirds = FixW'(43690);

  // Event kinds carried in tuser.
  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdStart = 2'd1,
    CmdEnd   = 2'd2,
    CmdSpare = 2'd3
  } cmd_e;

  // Configuration register indexes.
  localparam logic [2:0] RegRamp  = 3'd0;
  localparam logic [2:0] RegStay  = 3'd1;
  localparam logic [2:0] RegEnd   = 3'd2;
  localparam logic [2:0] RegFinal = 3'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // 8-bit part to a fraction: x*65536/255 = 257*x plus one when x is full scale.
  function automatic logic [FixW-1:0] part_fix(logic [7:0] x);
    logic [FixW-1:0] v;
    v = {1'b0, x, x} + FixW'(x == 8'hFF);
    return v;
  endfunction

  // Fraction back to an 8-bit channel, truncated: v*255 >> 16.
  function automatic logic [7:0] chan8(logic [FixW-1:0] v);
    logic [FixW+7:0] m;
    m = {v, 8'b0} - {8'b0, v};
    return (m[FixW+7:FracBits] > 9'd255) ? 8'hFF : m[FracBits+7:FracBits];
  endfunction

endpackage

// File: rtl/hslr_serial_mul.sv
// Shift-add multiplier taking one multiplier bit per cycle.
// Depends on hslr_pkg for operand widths and the status type.
module hslr_serial_mul import hslr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MulW-1:0]  a_i,
  input  logic [MulW-1:0]  b_i,
  output unit_stat_t       stat_o,
  output logic [ProdW-1:0] prod_o
);

  logic [MulW-1:0]    a_q, hi_q, lo_q;
  logic [MulCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [MulW:0]      sum;

  // add the multiplicand when the low bit is set, then shift the pair right
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= MulCntW'(MulW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - MulCntW'(1);
        if (cnt_q == MulCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= sum[MulW:1];
      lo_q <= {sum[0], lo_q[MulW-1:1]};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign prod_o = {hi_q, lo_q};

endmodule

// File: rtl/hslr_serial_div.sv
// Restoring divider for the time ratio, one quotient bit per cycle.
// Depends on hslr_pkg; saturates the ratio to one when num >= den.
module hslr_serial_div import hslr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output unit_stat_t      stat_o,
  output logic [FixW-1:0] quot_o
);

  logic [DenW-1:0]     den_q, rem_q;
  logic [DivSteps-1:0] q_q;
  logic                sat_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                busy_q, done_q;
  logic [DenW:0]       trial;
  logic                ge;

  assign trial = {rem_q, 1'b0};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (num_i >= {1'b0, den_i}) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= DivCntW'(DivSteps);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= num_i[DenW-1:0];
      q_q   <= '0;
      sat_q <= num_i >= {1'b0, den_i};
    end else if (busy_q) begin
      rem_q <= ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      q_q   <= {q_q[DivSteps-2:0], ge};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = sat_q ? One : {1'b0, q_q};

endmodule

// File: rtl/hsl_ramp_rgbw_light_sequencer.sv
// HSL colour ramp sequencer with RGBW drive; top level.
// Depends on hslr_pkg, hslr_serial_div and hslr_serial_mul.
//
// One input word is one event: start (elapsed count to zero), end (light off,
// idle) or tick (add sec_delta seconds, zero counting as one). Each event gives
// exactly one output word with the RGBW drive and elapsed count after it.
// Start, end, unused, idle ticks and ticks past the end of the sequence go from
// the idle state straight to the done state, which loads the output. A tick in
// the sequence runs the time ratio through a 16-step serial divider, then seven
// 17-bit shift-add multiplies one after another on one shared multiplier (three
// interpolations, the lightness/saturation product and three hue segments),
// then the pack state builds the drive and the done state loads the output.
// Input is taken only while the sequencer is idle; the output register holds a
// finished word while the next event is already being worked on. Configuration
// writes are always taken and must only be made while no event is in flight.
module hsl_ramp_rgbw_light_sequencer import hslr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] sec_delta
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue,
                                      // [31:24] white, [32] active,
                                      // [48:33] elapsed, [55:49] zero
);

  localparam logic [15:0] IdleMark = 16'hFFFF;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_LERP = 7'b0000100,
    S_QMUL = 7'b0001000,
    S_HUE  = 7'b0010000,
    S_PACK = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [13:0] ramp_q, stay_q;
  logic [23:0] end_col_q, fin_col_q;

  // sequence state
  logic [15:0] elapsed_q;
  logic [31:0] drive_q;

  // working registers
  logic            phase_a_q;
  logic [1:0]      idx_q;
  logic            started_q;
  logic [FixW-1:0] r_q, h_q, s_q, l_q, q_q, p_q;
  logic [7:0]      chan_q [3];
  logic            out_valid_q;
  logic [55:0]     out_data_q;

  // units
  unit_stat_t       mul_stat, div_stat;
  logic             mul_start, div_start;
  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] mul_prod;
  logic [FixW-1:0]  div_quot;
  logic [NumW-1:0]  div_num;
  logic [DenW-1:0]  div_den;
  logic [FixW-1:0]  step;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // tick arithmetic, kept one bit wider so nothing wraps
  logic [7:0]  delta1;
  logic [16:0] t_sum, t_next;
  logic [14:0] rs_sum;
  logic        in_ramp, in_stay;
  assign delta1  = (s_axis_tdata == 8'd0) ? 8'd1 : s_axis_tdata;
  assign t_sum   = {1'b0, elapsed_q} + {9'b0, delta1} - 17'd1;
  assign t_next  = t_sum + 17'd1;
  assign rs_sum  = {1'b0, ramp_q} + {1'b0, stay_q};
  assign in_ramp = t_sum < {3'b0, ramp_q};
  assign in_stay = t_sum <= {2'b0, rs_sum};

  assign div_start = accept && (s_axis_tuser == CmdTick) && (elapsed_q != IdleMark)
                     && in_stay;
  assign div_num   = in_ramp ? t_next[NumW-1:0]
                             : NumW'(t_next - {3'b0, ramp_q});
  assign div_den   = in_ramp ? ramp_q : stay_q;

  // interpolation endpoints; phase one runs lightness from zero, hue and
  // saturation held at the ramp end colour
  logic [7:0]      from_part, to_part;
  logic [FixW-1:0] from_fix, to_fix, mag;
  logic            neg;
  logic [FixW:0]   diff;
  always_comb begin
    case (idx_q)
      2'd0: begin
        from_part = end_col_q[23:16];
        to_part   = phase_a_q ? end_col_q[23:16] : fin_col_q[23:16];
      end
      2'd1: begin
        from_part = end_col_q[15:8];
        to_part   = phase_a_q ? end_col_q[15:8] : fin_col_q[15:8];
      end
      default: begin
        from_part = phase_a_q ? 8'd0 : end_col_q[7:0];
        to_part   = phase_a_q ? end_col_q[7:0] : fin_col_q[7:0];
      end
    endcase
  end
  assign from_fix = part_fix(from_part);
  assign to_fix   = part_fix(to_part);
  assign neg      = to_fix < from_fix;
  assign diff     = neg ? {1'b0, from_fix} - {1'b0, to_fix}
                        : {1'b0, to_fix} - {1'b0, from_fix};
  assign mag      = diff[FixW-1:0];

  assign step = mul_prod[FracBits+FixW-1:FracBits];

  // lerp result; the step is truncated, so the value rounds toward the start point
  logic [FixW-1:0] lerp_val;
  assign lerp_val = neg ? from_fix - step : from_fix + step;

  // q and p of the HSL conversion from the l*s product
  logic [FixW:0]   q_wide, p_wide;
  assign q_wide = (l_q < Half) ? {1'b0, l_q} + {1'b0, step}
                               : {1'b0, l_q} + {1'b0, s_q} - {1'b0, step};
  assign p_wide = {l_q, 1'b0} - q_wide;

  // hue segment for the channel in hand
  logic [FixW+1:0] h_shift, t_hue;
  logic [FixW-1:0] t_h, hue_op, hue_val, qp;
  logic [FixW+2:0] six_t;
  logic            seg_rise, seg_flat, seg_fall;
  always_comb begin
    case (idx_q)
      2'd0:    h_shift = {2'b0, h_q} + {2'b0, Third};
      2'd1:    h_shift = {2'b0, h_q};
      default: h_shift = {2'b0, h_q} - {2'b0, Third};
    endcase
    t_hue = h_shift;
    if (h_shift[FixW+1])
      t_hue = h_shift + {2'b0, One};
    else if (h_shift > {2'b0, One})
      t_hue = h_shift - {2'b0, One};
  end
  assign t_h      = t_hue[FixW-1:0];
  assign seg_rise = t_h < Sixth;
  assign seg_flat = !seg_rise && (t_h < Half);
  assign seg_fall = !seg_rise && !seg_flat && (t_h < TwoThirds);
  always_comb begin
    if (seg_rise)
      six_t = {3'b0, t_h} * (FixW+3)'(6);
    else if (seg_fall)
      six_t = {3'b0, TwoThirds - t_h} * (FixW+3)'(6);
    else
      six_t = '0;
  end
  assign hue_op  = six_t[FixW-1:0];
  assign qp      = q_q - p_q;
  assign hue_val = seg_flat ? q_q : p_q + step;

  // multiplier operands by step
  always_comb begin
    case (state_q)
      S_LERP:  begin mul_a = mag;  mul_b = r_q;    end
      S_QMUL:  begin mul_a = l_q;  mul_b = s_q;    end
      default: begin mul_a = qp;   mul_b = hue_op; end
    endcase
  end
  assign mul_start = !started_q &&
                     ((state_q == S_LERP) || (state_q == S_QMUL) || (state_q == S_HUE));

  // white is the smallest channel; take it off the other three
  logic [7:0] w_min;
  assign w_min = (chan_q[0] < chan_q[1])
                 ? ((chan_q[2] < chan_q[0]) ? chan_q[2] : chan_q[0])
                 : ((chan_q[2] < chan_q[1]) ? chan_q[2] : chan_q[1]);

  logic out_free, active;
  assign out_free = !out_valid_q || m_axis_tready;
  assign active   = {1'b0, elapsed_q} <= ({2'b0, rs_sum} + 17'd1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = div_start ? S_DIV : S_DONE;
      S_DIV:  if (div_stat.done) state_d = S_LERP;
      S_LERP: if (mul_stat.done && idx_q == 2'd2) state_d = S_QMUL;
      S_QMUL: if (mul_stat.done) state_d = S_HUE;
      S_HUE:  if (mul_stat.done && idx_q == 2'd2) state_d = S_PACK;
      S_PACK: state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ramp_q      <= 14'd600;
      stay_q      <= 14'd600;
      end_col_q   <= 24'h11C178;
      fin_col_q   <= 24'h21C190;
      elapsed_q   <= IdleMark;
      drive_q     <= '0;
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
      idx_q       <= '0;
      phase_a_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegRamp:  ramp_q    <= cfg_data_i[13:0];
          RegStay:  stay_q    <= cfg_data_i[13:0];
          RegEnd:   end_col_q <= cfg_data_i;
          RegFinal: fin_col_q <= cfg_data_i;
          default:  ;
        endcase
      end

      if (mul_start) started_q <= 1'b1;
      else if (mul_stat.done) started_q <= 1'b0;

      // load a finished word, or drop the one just taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q <= '0;
            case (s_axis_tuser)
              CmdStart: elapsed_q <= '0;
              CmdEnd: begin
                elapsed_q <= IdleMark;
                drive_q   <= '0;
              end
              CmdTick: begin
                if (elapsed_q == IdleMark || !in_stay) begin
                  elapsed_q <= IdleMark;
                  drive_q   <= '0;
                end else begin
                  elapsed_q <= t_next[15:0];
                  phase_a_q <= in_ramp;
                end
              end
              default: ;
            endcase
          end
        end
        S_LERP, S_HUE: if (mul_stat.done) idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        S_PACK: drive_q <= {chan_q[0] - w_min, chan_q[1] - w_min, chan_q[2] - w_min, w_min};
        default: ;
      endcase
    end
  end

  // datapath words, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV && div_stat.done) r_q <= div_quot;
    if (state_q == S_LERP && mul_stat.done) begin
      case (idx_q)
        2'd0:    h_q <= lerp_val;
        2'd1:    s_q <= lerp_val;
        default: l_q <= lerp_val;
      endcase
    end
    if (state_q == S_QMUL && mul_stat.done) begin
      q_q <= q_wide[FixW-1:0];
      p_q <= p_wide[FixW-1:0];
    end
    if (state_q == S_HUE && mul_stat.done) chan_q[idx_q] <= chan8(hue_val);
    if (state_q == S_DONE && out_free)
      out_data_q <= {7'b0, elapsed_q, active, drive_q[7:0], drive_q[15:8],
                     drive_q[23:16], drive_q[31:24]};
  end

  hslr_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  hslr_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_stat),
    .prod_o  (mul_prod)
  );

  // units rest whenever the sequencer waits for an event
  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !(mul_stat.busy || div_stat.busy))
    else $error("arithmetic unit busy while sequencer idle");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_idle_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (elapsed_q == IdleMark) |-> (drive_q == 32'd0))
    else $error("light on while idle");

  a_ratio_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (div_quot <= One))
    else $error("time ratio above one");

endmodule
